[design/per_source_signal_strength_averager_defines.svh]
// assertion macros for the signal strength averager
`ifndef PER_SOURCE_SIGNAL_STRENGTH_AVERAGER_DEFINES_SVH
`define PER_SOURCE_SIGNAL_STRENGTH_AVERAGER_DEFINES_SVH
`ifndef SYNTH
`define PSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSA_ASSERT(label, clk, rst_n, prop, msg)
`define PSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[design/psa_pkg.sv]
package psa_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY,
        ST_FREE,
        ST_SLOT_RD,
        ST_SLOT,
        ST_ACC,
        ST_FIN_RD,
        ST_FIN,
        ST_DIV,
        ST_DIV_END,
        ST_OUT
    } t_state;

    localparam logic [2:0] STATUS_ACCUM     = 3'd0;
    localparam logic [2:0] STATUS_NO_ENTRY  = 3'd1;
    localparam logic [2:0] STATUS_NO_SLOT   = 3'd2;
    localparam logic [2:0] STATUS_FINISHED  = 3'd3;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctrl;
endpackage

[design/psa_divider.sv]
module psa_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_busy,
    output logic [15:0] o_quotient
);
    // restoring divider, one quotient bit per cycle
    logic [15:0] r_quot;
    logic [8:0]  r_rem;
    logic [7:0]  r_dvs;
    logic [4:0]  r_cnt;
    logic [8:0]  w_shift;
    logic [9:0]  w_diff;

    assign w_shift = {r_rem[7:0], r_quot[15]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_cnt != 5'd0) begin
            if (!w_diff[9]) begin
                r_rem  <= w_diff[8:0];
                r_quot <= {r_quot[14:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[14:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_cnt != 5'd0);
    assign o_quotient = r_quot;
endmodule

[design/per_source_signal_strength_averager.sv]
// per-source signal strength averager
// input channel: i_valid / o_stall with mode, source_id, truth_value,
// receiver_id and strength; output channel: o_valid / i_stall with status,
// best_receiver and best_average, one result transaction per input
// transaction.
// the block takes one transaction at a time: o_stall is high from the
// accepting edge until its result has been taken.
// an accumulate does one key compare per cycle, then reads the slot memory
// one slot word at a time, each read taking a read state and a check state;
// a finish adds, per used slot, the slot read and a run of the shared
// radix-2 divider (16 steps).
// at reset the key table and the slot valid bits clear, so an
// unwritten slot reads as zero; no clearing pass is needed.
// while the receiver stalls, the result holds in the output register and no
// new transaction is accepted.
module per_source_signal_strength_averager #(
    parameter int TABLE_ENTRIES       = 8,
    parameter int RECEIVERS_PER_ENTRY = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [19:0] i_source_id,
    input  logic [15:0] i_truth_value,
    input  logic [7:0]  i_receiver_id,
    input  logic [7:0]  i_strength,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_best_receiver,
    output logic [7:0]  o_best_average
);
    import psa_pkg::*;
    `include "per_source_signal_strength_averager_defines.svh"

    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RW = (RECEIVERS_PER_ENTRY > 1) ? $clog2(RECEIVERS_PER_ENTRY) : 1;
    localparam int SLOTS = TABLE_ENTRIES * RECEIVERS_PER_ENTRY;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [EW:0] ELAST = (EW+1)'(TABLE_ENTRIES - 1);
    localparam logic [RW:0] RLAST = (RW+1)'(RECEIVERS_PER_ENTRY - 1);

    t_state r_state, n_state;

    logic [19:0] r_ent_src [TABLE_ENTRIES];
    logic [15:0] r_ent_tru [TABLE_ENTRIES];
    logic [SLOTS-1:0] r_slot_vld;
    logic [31:0] m_slot [SLOTS];
    logic [31:0] r_rd;

    logic        r_mode;
    logic [19:0] r_src;
    logic [15:0] r_tru;
    logic [7:0]  r_rcv;
    logic [7:0]  r_str;
    logic [EW:0] r_e;
    logic [RW:0] r_r;
    logic [2:0]  r_status;
    logic [7:0]  r_best_rcv;
    logic [7:0]  r_best_avg;
    logic        r_valid;

    logic [EW-1:0] w_e;
    logic [RW-1:0] w_r;
    logic [SW-1:0] w_addr;
    logic [31:0]   w_word;
    logic [7:0]    w_srcv;
    logic [15:0]   w_ssum;
    logic [7:0]    w_scnt;
    logic          w_key_hit;
    logic          w_accept;
    t_div_ctrl     w_div;
    logic [15:0]   w_quot;
    logic [7:0]    w_avg;
    logic          w_we;
    logic [31:0]   w_wdata;

    assign w_e    = r_e[EW-1:0];
    assign w_r    = r_r[RW-1:0];
    assign w_addr = SW'(w_e * RECEIVERS_PER_ENTRY + w_r);
    assign w_word = r_slot_vld[w_addr] ? r_rd : 32'd0;
    assign w_srcv = w_word[31:24];
    assign w_ssum = w_word[23:8];
    assign w_scnt = w_word[7:0];
    assign w_key_hit = (r_ent_src[w_e] == r_src) && (r_ent_tru[w_e] == r_tru);
    assign w_accept  = i_valid && !o_stall;

    assign w_div.start = (r_state == ST_FIN) && (w_srcv != 8'd0);

    psa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div.start),
        .i_dividend (w_ssum),
        .i_divisor  (w_scnt),
        .o_busy     (w_div.busy),
        .o_quotient (w_quot)
    );
    // count 0 divides to all ones; force the average to 0 then
    assign w_avg = (w_scnt == 8'd0) ? 8'd0 :
                   (w_quot > 16'd255) ? 8'd255 : w_quot[7:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_accept) n_state = ST_KEY;
            ST_KEY: begin
                if (w_key_hit) begin
                    n_state = r_mode ? ST_FIN_RD : ST_SLOT_RD;
                end else if (r_e == ELAST) begin
                    n_state = r_mode ? ST_OUT : ST_FREE;
                end
            end
            ST_FREE: begin
                if (r_ent_src[w_e] == 20'd0) n_state = ST_SLOT_RD;
                else if (r_e == ELAST) n_state = ST_OUT;
            end
            ST_SLOT_RD: n_state = ST_SLOT;
            ST_SLOT: begin
                if (w_srcv == r_rcv || w_srcv == 8'd0) n_state = ST_ACC;
                else if (r_r == RLAST) n_state = ST_OUT;
                else n_state = ST_SLOT_RD;
            end
            ST_ACC:     n_state = ST_OUT;
            ST_FIN_RD:  n_state = ST_FIN;
            ST_FIN:     n_state = (w_srcv == 8'd0) ? ST_OUT : ST_DIV;
            ST_DIV:     if (!w_div.busy) n_state = ST_DIV_END;
            ST_DIV_END: n_state = (r_r == RLAST) ? ST_OUT : ST_FIN_RD;
            ST_OUT:     if (r_valid && !i_stall) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_word;
        unique case (r_state)
            ST_ACC: begin
                w_we = 1'b1;
                w_wdata[31:24] = r_rcv;
                if (w_scnt != 8'd255) begin
                    w_wdata[23:8] = w_ssum + 16'(r_str);
                    w_wdata[7:0]  = w_scnt + 8'd1;
                end
            end
            ST_DIV_END: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) m_slot[w_addr] <= w_wdata;
        r_rd <= m_slot[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_slot_vld <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_ent_src[i] <= '0;
                r_ent_tru[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_we) r_slot_vld[w_addr] <= 1'b1;
            if (r_state == ST_FREE && r_ent_src[w_e] == 20'd0) begin
                r_ent_src[w_e] <= r_src;
                r_ent_tru[w_e] <= r_tru;
            end
            if (r_state == ST_KEY && w_key_hit && r_mode) begin
                r_ent_src[w_e] <= '0;
                r_ent_tru[w_e] <= '0;
            end
            if (r_state == ST_OUT && r_valid && !i_stall) r_valid <= 1'b0;
            else if (n_state == ST_OUT && r_state != ST_OUT) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_mode     <= i_mode;
                    r_src      <= i_source_id;
                    r_tru      <= i_truth_value;
                    r_rcv      <= i_receiver_id;
                    r_str      <= i_strength;
                    r_best_rcv <= i_receiver_id;
                    r_best_avg <= i_strength;
                    r_e        <= '0;
                    r_r        <= '0;
                end
            end
            ST_KEY: begin
                if (w_key_hit) begin
                    r_r <= '0;
                    if (r_mode) begin
                        r_status   <= STATUS_FINISHED;
                        r_best_avg <= 8'd1;
                    end
                end else if (r_e == ELAST) begin
                    r_e      <= '0;
                    r_status <= r_mode ? STATUS_NOT_FOUND : STATUS_NO_ENTRY;
                end else begin
                    r_e <= r_e + 1'b1;
                end
            end
            ST_FREE: begin
                if (r_ent_src[w_e] != 20'd0 && r_e != ELAST) r_e <= r_e + 1'b1;
            end
            ST_SLOT: begin
                if (w_srcv == r_rcv || w_srcv == 8'd0) r_status <= STATUS_ACCUM;
                else if (r_r == RLAST) r_status <= STATUS_NO_SLOT;
                else r_r <= r_r + 1'b1;
            end
            ST_DIV_END: begin
                if (w_avg > r_best_avg) begin
                    r_best_avg <= w_avg;
                    r_best_rcv <= w_srcv;
                end
                if (r_r != RLAST) r_r <= r_r + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_best_receiver = r_best_rcv;
    assign o_best_average  = r_best_avg;

    `PSA_ASSERT(a_valid_in_out, i_clk, i_rst_n, o_valid |-> r_state == ST_OUT, "valid outside output state")
    `PSA_ASSERT(a_busy_stall, i_clk, i_rst_n, (r_state != ST_IDLE) |-> o_stall, "accepted while busy")
    `PSA_ASSERT(a_div_once, i_clk, i_rst_n, w_div.start |=> w_div.busy, "divider did not start")
    `PSA_ASSERT(a_status_range, i_clk, i_rst_n, o_valid |-> o_status <= STATUS_NOT_FOUND, "bad status")
    `PSA_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_state == ST_IDLE && !o_valid, "reset not idle")
endmodule
